### hw/rtl/bta_pkg.sv
// Shared types, constants and command codes of the boundary-tag heap allocator.
`default_nettype none
package bta_pkg;

  localparam int HEAP_WORDS = 65536;
  localparam int WORD_BYTES = 4;
  localparam int IDX_W      = 16;
  localparam int AW         = 20;
  localparam int CFG_W      = 17;

  localparam logic [21:0]    HEAP_CAP    = 22'(HEAP_WORDS * WORD_BYTES);
  localparam logic [AW-1:0]  MIN_BLOCK   = 20'd16;
  localparam logic [AW-1:0]  DBL_BYTES   = 20'd8;
  localparam logic [AW-1:0]  WORD_B      = 20'd4;
  localparam logic [AW-1:0]  FIRST_BP    = 20'd8;
  localparam logic [AW-1:0]  TOP_RESET   = 20'd4112;
  localparam logic [CFG_W-1:0] CHUNK_RESET = 17'd4096;
  localparam logic [2:0]     INIT_LAST   = 3'd4;

  typedef struct packed {
    logic        op;
    logic [18:0] req_size;
    logic [17:0] block_addr;
  } in_t;

  typedef struct packed {
    logic [17:0] result_addr;
    logic [1:0]  status;
  } out_t;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  typedef logic [4:0] cmd_t;
  localparam cmd_t CMD_NOP      = 5'd0;
  localparam cmd_t CMD_INIT     = 5'd1;
  localparam cmd_t CMD_LOAD     = 5'd2;
  localparam cmd_t CMD_ADV      = 5'd3;
  localparam cmd_t CMD_HOLD     = 5'd4;
  localparam cmd_t CMD_GR_EPI   = 5'd5;
  localparam cmd_t CMD_M_RP     = 5'd6;
  localparam cmd_t CMD_M_RN     = 5'd7;
  localparam cmd_t CMD_M_CAP    = 5'd8;
  localparam cmd_t CMD_M_W1     = 5'd9;
  localparam cmd_t CMD_M_W2     = 5'd10;
  localparam cmd_t CMD_PL_H     = 5'd11;
  localparam cmd_t CMD_PL_F     = 5'd12;
  localparam cmd_t CMD_PL_SH    = 5'd13;
  localparam cmd_t CMD_PL_SF    = 5'd14;
  localparam cmd_t CMD_RES_OK   = 5'd15;
  localparam cmd_t CMD_RES_NULL = 5'd16;
  localparam cmd_t CMD_RES_OOM  = 5'd17;

  typedef struct packed {
    logic tag_zero;
    logic tag_alloc;
    logic fit;
    logic match;
    logic split;
    logic oom;
    logic req_zero;
    logic is_free;
    logic init_last;
  } stat_t;

  // Word index into the tag store of a byte offset.
  function automatic logic [IDX_W-1:0] widx(input logic [AW-1:0] a);
    return a[IDX_W+1:2];
  endfunction

  // Tag words of the heap after reset: prologue, one free block, epilogue.
  function automatic logic [IDX_W-1:0] init_idx(input logic [2:0] n);
    logic [IDX_W-1:0] r;
    unique case (n)
      3'd0:    r = 16'd1;
      3'd1:    r = 16'd2;
      3'd2:    r = 16'd3;
      3'd3:    r = 16'd1026;
      default: r = 16'd1027;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] init_data(input logic [2:0] n);
    logic [31:0] r;
    unique case (n)
      3'd0, 3'd1: r = 32'd9;
      3'd2, 3'd3: r = 32'd4096;
      default:    r = 32'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/bta_dp.sv
// Datapath of the allocator: tag store, block pointers, size arithmetic and result registers.
`default_nettype none
module bta_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bta_pkg::cmd_t                cmd,
  output bta_pkg::stat_t                    stat,
  input  wire bta_pkg::in_t                 item,
  input  wire logic                         cfg_valid,
  input  wire logic [bta_pkg::CFG_W-1:0]    cfg_data,
  output bta_pkg::out_t                     result
);

  logic [31:0] mem [bta_pkg::HEAP_WORDS];
  logic [31:0] rdata;

  logic                    op;
  logic [18:0]             req;
  logic [17:0]             addr;
  logic [bta_pkg::AW-1:0]  need;
  logic [bta_pkg::AW-1:0]  bp;
  logic [bta_pkg::AW-1:0]  have;
  logic                    first;
  logic [bta_pkg::AW-1:0]  ps_size;
  logic                    ps_free;
  logic [bta_pkg::AW-1:0]  nt_size;
  logic                    nt_free;
  logic [bta_pkg::AW-1:0]  heap_top;
  logic [bta_pkg::CFG_W-1:0] chunk;
  logic [17:0]             res_addr;
  logic [1:0]              res_status;
  logic [2:0]              init_cnt;

  logic [bta_pkg::AW-1:0]  tag_size;
  logic [bta_pkg::AW-1:0]  need_next;
  logic [bta_pkg::AW:0]    req_round;
  logic [bta_pkg::AW-1:0]  ext;
  logic [18:0]             gwords;
  logic [20:0]             gsize;
  logic [21:0]             grow_end;
  logic [bta_pkg::AW-1:0]  rem;
  logic                    split;
  logic [bta_pkg::AW-1:0]  msize;
  logic [bta_pkg::AW-1:0]  base;
  logic [bta_pkg::AW-1:0]  pl_size;

  logic                    we;
  logic [bta_pkg::IDX_W-1:0] wa;
  logic [31:0]             wd;
  logic [bta_pkg::IDX_W-1:0] ra;

  always_comb begin
    tag_size  = {rdata[bta_pkg::AW-1:3], 3'b000};
    req_round = 21'(item.req_size) + 21'd15;
    need_next = (item.req_size <= 19'd8) ? bta_pkg::MIN_BLOCK
                                         : {req_round[bta_pkg::AW-1:3], 3'b000};
    ext       = (need > 20'(chunk)) ? need : 20'(chunk);
    // Growth is a whole, even number of words.
    gwords    = {1'b0, ext[19:2]} + 19'(ext[2]);
    gsize     = {gwords, 2'b00};
    grow_end  = 22'(heap_top) + 22'(gsize);
    rem       = have - need;
    split     = rem >= bta_pkg::MIN_BLOCK;
    pl_size   = split ? need : have;
    msize     = have + (ps_free ? ps_size : '0) + (nt_free ? nt_size : '0);
    base      = ps_free ? (bp - ps_size) : bp;
  end

  always_comb begin
    stat.tag_zero  = (tag_size == '0);
    stat.tag_alloc = rdata[0];
    stat.fit       = !rdata[0] && (need <= tag_size);
    stat.match     = !first && (bp == 20'(addr));
    stat.split     = split;
    stat.oom       = grow_end > bta_pkg::HEAP_CAP;
    stat.req_zero  = (req == '0);
    stat.is_free   = (op == bta_pkg::OP_FREE);
    stat.init_last = (init_cnt == bta_pkg::INIT_LAST);
  end

  always_comb begin
    we = 1'b0;
    wa = bta_pkg::widx(bp - bta_pkg::WORD_B);
    wd = '0;
    ra = bta_pkg::widx(bp - bta_pkg::WORD_B);
    unique case (cmd)
      bta_pkg::CMD_INIT: begin
        we = 1'b1;
        wa = bta_pkg::init_idx(init_cnt);
        wd = bta_pkg::init_data(init_cnt);
      end
      bta_pkg::CMD_LOAD: ra = bta_pkg::widx(bta_pkg::FIRST_BP - bta_pkg::WORD_B);
      bta_pkg::CMD_ADV:  ra = bta_pkg::widx(bp + tag_size - bta_pkg::WORD_B);
      bta_pkg::CMD_GR_EPI: begin
        we = 1'b1;
        wa = bta_pkg::widx(grow_end[bta_pkg::AW-1:0] - bta_pkg::WORD_B);
        wd = 32'd1;
      end
      bta_pkg::CMD_M_RP: ra = bta_pkg::widx(bp - bta_pkg::DBL_BYTES);
      bta_pkg::CMD_M_RN: ra = bta_pkg::widx(bp + have - bta_pkg::WORD_B);
      bta_pkg::CMD_M_W1: begin
        we = 1'b1;
        wa = bta_pkg::widx(base - bta_pkg::WORD_B);
        wd = 32'(msize);
      end
      bta_pkg::CMD_M_W2: begin
        we = 1'b1;
        wa = bta_pkg::widx(bp + have - bta_pkg::DBL_BYTES);
        wd = 32'(have);
      end
      bta_pkg::CMD_PL_H: begin
        we = 1'b1;
        wd = 32'(pl_size) | 32'd1;
      end
      bta_pkg::CMD_PL_F: begin
        we = 1'b1;
        wa = bta_pkg::widx(bp + pl_size - bta_pkg::DBL_BYTES);
        wd = 32'(pl_size) | 32'd1;
      end
      bta_pkg::CMD_PL_SH: begin
        we = 1'b1;
        wa = bta_pkg::widx(bp + need - bta_pkg::WORD_B);
        wd = 32'(rem);
      end
      bta_pkg::CMD_PL_SF: begin
        we = 1'b1;
        wa = bta_pkg::widx(bp + have - bta_pkg::DBL_BYTES);
        wd = 32'(rem);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_top   <= bta_pkg::TOP_RESET;
      chunk      <= bta_pkg::CHUNK_RESET;
      init_cnt   <= '0;
      res_addr   <= '0;
      res_status <= bta_pkg::ST_OK;
    end else begin
      if (cfg_valid) begin
        chunk <= cfg_data;
      end
      unique case (cmd)
        bta_pkg::CMD_INIT: init_cnt <= init_cnt + 3'd1;
        bta_pkg::CMD_LOAD: begin
          op         <= item.op;
          req        <= item.req_size;
          addr       <= item.block_addr;
          need       <= need_next;
          bp         <= bta_pkg::FIRST_BP;
          first      <= 1'b1;
          res_addr   <= '0;
          res_status <= bta_pkg::ST_OK;
        end
        bta_pkg::CMD_ADV: begin
          bp    <= bp + tag_size;
          have  <= tag_size;
          first <= 1'b0;
        end
        bta_pkg::CMD_HOLD: have <= tag_size;
        bta_pkg::CMD_GR_EPI: begin
          bp       <= heap_top;
          have     <= gsize[bta_pkg::AW-1:0];
          heap_top <= grow_end[bta_pkg::AW-1:0];
        end
        bta_pkg::CMD_M_RN: begin
          ps_size <= tag_size;
          ps_free <= !rdata[0];
        end
        bta_pkg::CMD_M_CAP: begin
          nt_size <= tag_size;
          nt_free <= !rdata[0];
        end
        bta_pkg::CMD_M_W1: begin
          bp   <= base;
          have <= msize;
        end
        bta_pkg::CMD_RES_OK:   res_addr <= bp[17:0];
        bta_pkg::CMD_RES_NULL: res_status <= bta_pkg::ST_NULL;
        bta_pkg::CMD_RES_OOM:  res_status <= bta_pkg::ST_OOM;
        default: ;
      endcase
    end
  end

  assign result.result_addr = res_addr;
  assign result.status      = res_status;

endmodule
`default_nettype wire

### hw/rtl/bta_ctrl.sv
// Controller state machine that sequences walks, growth, merging and placement.
`default_nettype none
module bta_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  output logic                done,
  output bta_pkg::cmd_t       cmd,
  input  wire bta_pkg::stat_t stat
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_GROW  = 4'd4;
  localparam logic [3:0] S_M_RP  = 4'd5;
  localparam logic [3:0] S_M_RN  = 4'd6;
  localparam logic [3:0] S_M_CAP = 4'd7;
  localparam logic [3:0] S_M_W1  = 4'd8;
  localparam logic [3:0] S_M_W2  = 4'd9;
  localparam logic [3:0] S_PL_H  = 4'd10;
  localparam logic [3:0] S_PL_F  = 4'd11;
  localparam logic [3:0] S_PL_SH = 4'd12;
  localparam logic [3:0] S_PL_SF = 4'd13;
  localparam logic [3:0] S_RES   = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = bta_pkg::CMD_NOP;
    unique case (state)
      S_INIT: begin
        cmd = bta_pkg::CMD_INIT;
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd        = bta_pkg::CMD_LOAD;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat.is_free && stat.req_zero) begin
          cmd        = bta_pkg::CMD_RES_NULL;
          state_next = S_DONE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.tag_zero) begin
          cmd        = bta_pkg::CMD_HOLD;
          state_next = stat.is_free ? S_DONE : S_GROW;
        end else if (stat.is_free && stat.match) begin
          cmd        = bta_pkg::CMD_HOLD;
          state_next = stat.tag_alloc ? S_M_RP : S_DONE;
        end else if (!stat.is_free && stat.fit) begin
          cmd        = bta_pkg::CMD_HOLD;
          state_next = S_PL_H;
        end else begin
          cmd = bta_pkg::CMD_ADV;
        end
      end
      S_GROW: begin
        if (stat.oom) begin
          cmd        = bta_pkg::CMD_RES_OOM;
          state_next = S_DONE;
        end else begin
          cmd        = bta_pkg::CMD_GR_EPI;
          state_next = S_M_RP;
        end
      end
      S_M_RP: begin
        cmd        = bta_pkg::CMD_M_RP;
        state_next = S_M_RN;
      end
      S_M_RN: begin
        cmd        = bta_pkg::CMD_M_RN;
        state_next = S_M_CAP;
      end
      S_M_CAP: begin
        cmd        = bta_pkg::CMD_M_CAP;
        state_next = S_M_W1;
      end
      S_M_W1: begin
        cmd        = bta_pkg::CMD_M_W1;
        state_next = S_M_W2;
      end
      S_M_W2: begin
        cmd        = bta_pkg::CMD_M_W2;
        state_next = stat.is_free ? S_DONE : S_PL_H;
      end
      S_PL_H: begin
        cmd        = bta_pkg::CMD_PL_H;
        state_next = S_PL_F;
      end
      S_PL_F: begin
        cmd        = bta_pkg::CMD_PL_F;
        state_next = stat.split ? S_PL_SH : S_RES;
      end
      S_PL_SH: begin
        cmd        = bta_pkg::CMD_PL_SH;
        state_next = S_PL_SF;
      end
      S_PL_SF: begin
        cmd        = bta_pkg::CMD_PL_SF;
        state_next = S_RES;
      end
      S_RES: begin
        cmd        = bta_pkg::CMD_RES_OK;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd == bta_pkg::CMD_LOAD) |-> (start && !busy))
    else $error("load command outside an accepted transaction");
`endif

endmodule
`default_nettype wire

### hw/rtl/boundary_tag_heap_allocator_top.sv
// Top level of the boundary-tag heap allocator: controller, datapath and ports.
`default_nettype none
// Each transaction is taken when start is high while busy is low, and its single result is
// shown on result for exactly one cycle with done high; the receiver cannot stall it, so it
// must take the result in that cycle. An allocate passes one block of the implicit list per
// cycle in its first-fit walk over the single tag memory port, then grows the heap and merges
// when no block fits, and then places the block; a free walks the same list to its block and,
// if it is allocated, merges it with free neighbours. A zero-size request answers without a
// walk. After reset the block writes the five initial heap tags with busy high. The chunk
// register can be written at any time busy is low; cfg_ready is always high.
module boundary_tag_heap_allocator_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire bta_pkg::in_t              item,
  output logic                           done,
  output bta_pkg::out_t                  result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [bta_pkg::CFG_W-1:0] cfg_data
);

  bta_pkg::cmd_t  cmd;
  bta_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  bta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  bta_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench of the boundary-tag heap allocator: stimulus, heap predictor and result checks.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HEAP_BYTES = 64'(bta_pkg::HEAP_WORDS) * 4;
  localparam int     WATCHDOG   = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bta_pkg::in_t  item = '0;
  logic done;
  bta_pkg::out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bta_pkg::CFG_W-1:0] cfg_data = '0;

  boundary_tag_heap_allocator_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted heap image and allocator state.
  logic [31:0] tags [0:bta_pkg::HEAP_WORDS-1];
  longint      heap_end;
  longint      chunk_bytes;

  bta_pkg::out_t pending_results[$];
  longint      live_blocks[$];
  longint      freed_blocks[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  function automatic logic [31:0] tag_at(longint a);
    longint i;
    i = a / 4;
    return (i < bta_pkg::HEAP_WORDS) ? tags[i] : 32'd0;
  endfunction

  function automatic void tag_put(longint a, longint v);
    longint i;
    i = a / 4;
    if (i < bta_pkg::HEAP_WORDS) tags[i] = 32'(v);
  endfunction

  function automatic longint blk_size(longint bp);
    return longint'(tag_at(bp - 4) & ~32'd7);
  endfunction

  function automatic bit is_used(longint bp);
    logic [31:0] t;
    t = tag_at(bp - 4);
    return t[0];
  endfunction

  function automatic void write_tags(longint bp, longint size, longint used);
    tag_put(bp - 4, size | used);
    tag_put(bp + size - 8, size | used);
  endfunction

  // Merges a free block with free neighbors; returns the merged block.
  function automatic longint coalesce(longint bp);
    longint p, n, size;
    bit pu, nu;
    p = bp - longint'(tag_at(bp - 8) & ~32'd7);
    n = bp + blk_size(bp);
    pu = is_used(p);
    nu = is_used(n);
    size = blk_size(bp);
    if (pu && nu) return bp;
    if (pu) begin
      write_tags(bp, size + blk_size(n), 0);
      return bp;
    end
    if (nu) begin
      write_tags(p, size + blk_size(p), 0);
      return p;
    end
    write_tags(p, size + blk_size(p) + blk_size(n), 0);
    return p;
  endfunction

  function automatic longint grow_heap(longint bytes);
    longint words, size, bp;
    words = bytes / 4;
    size = (words[0] ? words + 1 : words) * 4;
    if (size == 0 || heap_end + size > HEAP_BYTES) return 0;
    bp = heap_end;
    heap_end += size;
    write_tags(bp, size, 0);
    tag_put(bp + size - 4, 1);
    return coalesce(bp);
  endfunction

  function automatic void carve(longint bp, longint need);
    longint have;
    have = blk_size(bp);
    if (have - need >= 16) begin
      write_tags(bp, need, 1);
      write_tags(bp + need, have - need, 0);
    end else begin
      write_tags(bp, have, 1);
    end
  endfunction

  function automatic longint first_fit(longint need);
    longint bp;
    for (bp = 8; blk_size(bp) > 0; bp = bp + blk_size(bp))
      if (!is_used(bp) && need <= blk_size(bp)) return bp;
    return 0;
  endfunction

  function automatic void heap_reset();
    foreach (tags[i]) tags[i] = '0;
    tag_put(4, 9);
    tag_put(8, 9);
    tag_put(12, 1);
    heap_end = 16;
    chunk_bytes = 4096;
    void'(grow_heap(4096));
  endfunction

  function automatic bta_pkg::out_t predict_alloc_free(bta_pkg::in_t it);
    bta_pkg::out_t r;
    longint req, need, bp, addr;
    r = '0;
    r.status = bta_pkg::ST_OK;
    if (it.op == bta_pkg::OP_FREE) begin
      addr = longint'(it.block_addr);
      for (bp = 8 + blk_size(8); blk_size(bp) > 0; bp = bp + blk_size(bp)) begin
        if (bp == addr) begin
          if (is_used(bp)) begin
            write_tags(bp, blk_size(bp), 0);
            void'(coalesce(bp));
          end
          break;
        end
      end
      return r;
    end
    req = longint'(it.req_size);
    if (req == 0) begin
      r.status = bta_pkg::ST_NULL;
      return r;
    end
    need = (req <= 8) ? 16 : 8 * ((req + 15) / 8);
    bp = first_fit(need);
    if (bp == 0) begin
      bp = grow_heap((need > chunk_bytes) ? need : chunk_bytes);
      if (bp == 0) begin
        r.status = bta_pkg::ST_OOM;
        return r;
      end
    end
    carve(bp, need);
    r.result_addr = 18'(bp);
    return r;
  endfunction

  // Sends one transaction after a gap and records its expected result.
  task automatic send(bta_pkg::in_t it, int gap);
    bta_pkg::out_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    r = predict_alloc_free(it);
    pending_results.push_back(r);
    if (it.op == bta_pkg::OP_ALLOC && r.status == bta_pkg::ST_OK)
      live_blocks.push_back(longint'(r.result_addr));
  endtask

  task automatic send_alloc(longint size, int gap);
    bta_pkg::in_t it;
    it = '0;
    it.op = bta_pkg::OP_ALLOC;
    it.req_size = 19'(size);
    it.block_addr = 18'($urandom);
    send(it, gap);
  endtask

  task automatic send_free(longint addr, int gap);
    bta_pkg::in_t it;
    it = '0;
    it.op = bta_pkg::OP_FREE;
    it.req_size = 19'($urandom);
    it.block_addr = 18'(addr);
    send(it, gap);
  endtask

  // Frees the live block at a queue position.
  task automatic free_live(int k, int gap);
    longint a;
    a = live_blocks[k];
    live_blocks.delete(k);
    freed_blocks.push_back(a);
    if (freed_blocks.size() > 16) freed_blocks.pop_front();
    send_free(a, gap);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
  endtask

  task automatic write_chunk(longint v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v[bta_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chunk_bytes = v;
  endtask

  task automatic test_directed();
    int k;
    send_alloc(0, 0);
    send_alloc(1, 0);
    send_alloc(8, 0);
    send_alloc(9, 0);
    send_alloc(262144, 0);
    send_alloc(4000, 0);
    send_alloc(5000, 0);
    // Four neighbor cases: b alone, a beside free b, d beside epilogue side, c between.
    for (k = 0; k < 4; k++) send_alloc(24 + 8 * k, 0);
    k = live_blocks.size();
    free_live(k - 3, 0);
    free_live(k - 4, 0);
    free_live(k - 3, 0);
    free_live(k - 4, 0);
    send_free(freed_blocks[$], 0);
    send_free(8, 0);
    send_free(0, 0);
    send_free(18'h3ffff, 0);
    send_free(live_blocks[0] + 4, 0);
    send_alloc(19'h7ffff, 0);
  endtask

  task automatic test_chunk_extremes();
    write_chunk(16);
    send_alloc(300000, 0);
    send_alloc(5000, 0);
    send_alloc(8, 0);
    write_chunk(65536);
    send_alloc(70000, 0);
    send_alloc(100, 0);
    write_chunk(24);
    send_alloc(200, 0);
  endtask

  task automatic test_random(int count);
    int n, r, g;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      if ((n / 150) % 2 == 1) g = 0;
      if (live_blocks.size() > 60 && r < 50) r = 60;
      if (r < 3) send_alloc(0, g);
      else if (r < 6) send_alloc($urandom_range(0, 262144), g);
      else if (r < 44) send_alloc($urandom_range(1, 256), g);
      else if (r < 50) send_alloc($urandom_range(1, 9000), g);
      else if (r < 88 && live_blocks.size() > 0)
        free_live($urandom_range(0, live_blocks.size() - 1), g);
      else if (r < 94) send_free($urandom_range(0, 18'h3ffff), g);
      else if (freed_blocks.size() > 0)
        send_free(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)], g);
      else send_free(8, g);
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
  endtask

  // Each result is compared with the oldest expectation.
  always @(posedge clk) begin
    bta_pkg::out_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: addr %0d status %0d",
                                       result.result_addr, result.status);
      end else begin
        exp_r = pending_results.pop_front();
        if (result.result_addr !== exp_r.result_addr || result.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                     exp_r.result_addr, exp_r.status, result.result_addr, result.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("** boundary_tag_heap_allocator_top: FAILED **");
      $finish;
    end
  end

  initial begin
    heap_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_chunk_extremes();
    write_chunk(4096);
    test_random(600);
    write_chunk(65536);
    test_random(300);
    write_chunk(16);
    test_random(300);
    write_chunk(1000);
    test_random(600);
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** boundary_tag_heap_allocator_top: PASSED **");
    end else begin
      $display("** boundary_tag_heap_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
